@@ hw/rtl/assert_macros.svh @@
// -----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// ante must hold -> cons holds in the same cycle
`define PK_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// cond must never be seen at a clock edge
`define PK_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PK_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define PK_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ hw/rtl/pk1unpad_pkg.sv @@
// -----------------------------------------------------------------------------
// PKCS#1 v1.5 unpad package
// Shared widths, codes, reset values and beat types.
// -----------------------------------------------------------------------------
package pk1unpad_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 10;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'h02;

   // done status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FORMAT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CAPACITY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_BYTES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_CAPACITY = 2'd1;

   localparam logic [LEN_W-1:0] MODULUS_BYTES_RESET   = 10'd256;
   localparam logic [LEN_W-1:0] OUTPUT_CAPACITY_RESET = 10'd512;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic [LEN_W-1:0]  total_len;
      logic              is_last;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic                byte_valid;
      logic                done_res;
      logic [STATUS_W-1:0] status;
   } result_type;

   typedef struct packed {
      logic [LEN_W-1:0] modulus_bytes;
      logic [LEN_W-1:0] output_capacity;
   } cfg_type;

endpackage

@@ hw/rtl/pk1unpad_req_if.sv @@
// -----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one byte of the encoded block per beat.
// -----------------------------------------------------------------------------
interface pk1unpad_req_if;
   import pk1unpad_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic [LEN_W-1:0]  total_len;
   logic              is_last;

   modport source (output valid, output in_byte, output total_len, output is_last,
                   input ready);
   modport sink   (input valid, input in_byte, input total_len, input is_last,
                   output ready);
endinterface

@@ hw/rtl/pk1unpad_rsp_if.sv @@
// -----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying a message byte and/or the done status.
// -----------------------------------------------------------------------------
interface pk1unpad_rsp_if;
   import pk1unpad_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic                byte_valid;
   logic                done_res;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output out_byte, output byte_valid, output done_res,
                   output status, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input done_res,
                   input status, output ready);
endinterface

@@ hw/rtl/pk1unpad_csr_if.sv @@
// -----------------------------------------------------------------------------
// Register write channel
// Valid/ready channel carrying a register index and write data.
// -----------------------------------------------------------------------------
interface pk1unpad_csr_if;
   import pk1unpad_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/pk1unpad_csr_regs.sv @@
// -----------------------------------------------------------------------------
// Configuration registers
// Modulus length and output capacity, written through the register channel.
// -----------------------------------------------------------------------------
module pk1unpad_csr_regs (
   input  logic                  clock,
   input  logic                  reset,
   pk1unpad_csr_if.sink          csr_if,
   output pk1unpad_pkg::cfg_type cfg
);
   import pk1unpad_pkg::*;

   cfg_type cfg_ff;
   logic    wr;

   assign csr_if.ready = 1'b1;
   assign wr           = csr_if.valid;
   assign cfg          = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.modulus_bytes   <= MODULUS_BYTES_RESET;
         cfg_ff.output_capacity <= OUTPUT_CAPACITY_RESET;
      end else if (wr) begin
         // indexes beyond the list are dropped
         if (csr_if.index == CSR_MODULUS_BYTES) begin
            cfg_ff.modulus_bytes <= csr_if.data;
         end
         if (csr_if.index == CSR_OUTPUT_CAPACITY) begin
            cfg_ff.output_capacity <= csr_if.data;
         end
      end
   end
endmodule

@@ hw/rtl/pk1unpad_decode.sv @@
// -----------------------------------------------------------------------------
// Padding decoder
// Per-byte phase tracking, format and capacity checks, and result forming.
// -----------------------------------------------------------------------------
module pk1unpad_decode #(
   parameter int MAX_BLOCK_BYTES = 512
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  pk1unpad_pkg::item_type   item,
   input  pk1unpad_pkg::cfg_type    cfg,
   output logic                     has_rsp,
   output pk1unpad_pkg::result_type rsp
);
   import pk1unpad_pkg::*;

   localparam int CMP_W = $clog2(MAX_BLOCK_BYTES + 1) + LEN_W;

   typedef enum logic [1:0] {PH_LEAD, PH_MARK, PH_PAD, PH_MSG} phase_type;

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] blen_ff, blen_in;
   logic             fmt_err_ff, fmt_err_in;
   logic             cap_err_ff, cap_err_in;

   logic [LEN_W:0]   used;
   logic [LEN_W-1:0] mlen;
   logic             oversize;
   logic             len_mismatch;
   logic             emit;

   assign used         = {1'b0, idx_ff} + {{LEN_W{1'b0}}, 1'b1};
   assign mlen         = ({1'b0, blen_ff} > used) ? LEN_W'({1'b0, blen_ff} - used) : '0;
   assign oversize     = CMP_W'(item.total_len) > CMP_W'(MAX_BLOCK_BYTES);
   assign len_mismatch = item.total_len != blen_ff;

   always_comb begin
      phase_in   = phase_ff;
      blen_in    = blen_ff;
      fmt_err_in = fmt_err_ff;
      cap_err_in = cap_err_ff;

      unique case (phase_ff)
         PH_LEAD: begin
            blen_in = item.total_len;
            if (oversize) fmt_err_in = 1'b1;
            if (item.total_len == cfg.modulus_bytes) begin
               if (item.in_byte != '0) fmt_err_in = 1'b1;
               phase_in = PH_MARK;
            end else begin
               // no leading zero: block must be one byte short of k
               if (({1'b0, item.total_len} + {{LEN_W{1'b0}}, 1'b1}) !=
                   {1'b0, cfg.modulus_bytes}) fmt_err_in = 1'b1;
               if (item.in_byte != MARKER_BYTE) fmt_err_in = 1'b1;
               phase_in = PH_PAD;
            end
         end
         PH_MARK: begin
            if (len_mismatch) fmt_err_in = 1'b1;
            if (item.in_byte != MARKER_BYTE) fmt_err_in = 1'b1;
            phase_in = PH_PAD;
         end
         PH_PAD: begin
            if (len_mismatch) fmt_err_in = 1'b1;
            if (item.in_byte == '0) begin
               if (mlen > cfg.output_capacity) cap_err_in = 1'b1;
               phase_in = PH_MSG;
            end
         end
         PH_MSG: begin
            if (len_mismatch) fmt_err_in = 1'b1;
         end
         default: begin
            phase_in = PH_LEAD;
         end
      endcase

      if (idx_ff >= blen_in) fmt_err_in = 1'b1;
      if (item.is_last) begin
         if (used != {1'b0, blen_in}) fmt_err_in = 1'b1;
         if (phase_in != PH_MSG) fmt_err_in = 1'b1;
      end

      idx_in = (idx_ff != '1) ? LEN_W'(used) : idx_ff;
   end

   assign emit    = (phase_ff == PH_MSG) && !fmt_err_in && !cap_err_in;
   assign has_rsp = emit || item.is_last;

   always_comb begin
      rsp.out_byte   = emit ? item.in_byte : '0;
      rsp.byte_valid = emit;
      rsp.done_res   = item.is_last;
      rsp.status     = STATUS_OK;
      if (item.is_last) begin
         priority if (fmt_err_in) rsp.status = STATUS_FORMAT;
         else if (cap_err_in)     rsp.status = STATUS_CAPACITY;
         else                     rsp.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEAD;
         idx_ff     <= '0;
         blen_ff    <= '0;
         fmt_err_ff <= 1'b0;
         cap_err_ff <= 1'b0;
      end else if (step) begin
         if (item.is_last) begin
            // end of block: back to the start state
            phase_ff   <= PH_LEAD;
            idx_ff     <= '0;
            blen_ff    <= '0;
            fmt_err_ff <= 1'b0;
            cap_err_ff <= 1'b0;
         end else begin
            phase_ff   <= phase_in;
            idx_ff     <= idx_in;
            blen_ff    <= blen_in;
            fmt_err_ff <= fmt_err_in;
            cap_err_ff <= cap_err_in;
         end
      end
   end
endmodule

@@ hw/rtl/pk1unpad_rsp_reg.sv @@
// -----------------------------------------------------------------------------
// Response register
// Holds one result beat until the consumer takes it.
// -----------------------------------------------------------------------------
module pk1unpad_rsp_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  pk1unpad_pkg::result_type data,
   output logic                     free,
   pk1unpad_rsp_if.source           rsp_if
);
   import pk1unpad_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   // slot is free when empty or its beat leaves this cycle
   assign free = !valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load && free) begin
         data_ff <= data;
      end
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.out_byte   = data_ff.out_byte;
   assign rsp_if.byte_valid = data_ff.byte_valid;
   assign rsp_if.done_res   = data_ff.done_res;
   assign rsp_if.status     = data_ff.status;
endmodule

@@ hw/rtl/pkcs1_v15_encryption_unpad.sv @@
// -----------------------------------------------------------------------------
// PKCS#1 v1.5 encryption unpad
// Streams a decrypted block byte by byte and returns message bytes and status.
// -----------------------------------------------------------------------------
// Path: an accepted request beat goes into the input register, then through
//   decode into the response register.
// Throughput: one byte per cycle; bytes that give no response never wait on
//   the response register, bytes that do wait only while it is full and stalled.
// Reset: synchronous; clears the pipeline valids and the block state, and
//   loads modulus_bytes = 256 and output_capacity = 512.
`include "assert_macros.svh"

module pkcs1_v15_encryption_unpad #(
   parameter int MAX_BLOCK_BYTES = 512
) (
   input  logic           clock,
   input  logic           reset,
   pk1unpad_req_if.sink   req_if,
   pk1unpad_rsp_if.source rsp_if,
   pk1unpad_csr_if.sink   csr_if
);
   import pk1unpad_pkg::*;

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       s1_move;
   logic       rsp_free;
   logic       step_has_rsp;
   result_type step_rsp;
   cfg_type    cfg;

   assign s1_move      = in_valid_ff && (!step_has_rsp || rsp_free);
   assign req_if.ready = !in_valid_ff || s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_item_ff.in_byte   <= req_if.in_byte;
         in_item_ff.total_len <= req_if.total_len;
         in_item_ff.is_last   <= req_if.is_last;
      end
   end

   pk1unpad_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   pk1unpad_decode #(
      .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
   ) u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (s1_move),
      .item    (in_item_ff),
      .cfg     (cfg),
      .has_rsp (step_has_rsp),
      .rsp     (step_rsp)
   );

   pk1unpad_rsp_reg u_rsp (
      .clock  (clock),
      .reset  (reset),
      .load   (s1_move && step_has_rsp),
      .data   (step_rsp),
      .free   (rsp_free),
      .rsp_if (rsp_if)
   );

   // a held input beat only ever waits on a stalled full response register
   `PK_ASSERT_IMPLY(a_hold_only_on_stall, clock, reset, in_valid_ff && !s1_move, rsp_if.valid && !rsp_if.ready, "input stage held without a stalled response")
   // every response beat carries a message byte or the done status
   `PK_ASSERT_IMPLY(a_rsp_not_empty, clock, reset, rsp_if.valid, rsp_if.byte_valid || rsp_if.done_res, "empty response beat")
   // message bytes are only released while no error is known
   `PK_ASSERT_IMPLY(a_emit_clean, clock, reset, rsp_if.valid && rsp_if.byte_valid, rsp_if.status == STATUS_OK, "message byte with error status")
   // status is only meaningful at done
   `PK_ASSERT_IMPLY(a_status_at_done, clock, reset, rsp_if.valid && !rsp_if.done_res, rsp_if.status == STATUS_OK, "status set without done")
endmodule

@@ dv/pkcs1_v15_encryption_unpad_tb.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// PKCS#1 v1.5 encryption unpad testbench
// Feeds encoded blocks one byte per beat, runs a cycle-free decoder alongside
// and compares every response beat. A directed table opens the run, followed
// by random phases of well-formed and damaged blocks under changing settings,
// with random idling on both channels.
// -----------------------------------------------------------------------------
module pkcs1_v15_encryption_unpad_tb;
   import pk1unpad_pkg::*;

   localparam int MAX_BLOCK    = 512;
   localparam int IDX_SAT      = 1023;
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEM_TARGET  = 1700;
   localparam int PHASE_ITEMS  = 60;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef enum logic [1:0] {ST_LEAD, ST_MARK, ST_PAD, ST_MSG} unpad_phase_type;
   typedef enum logic       {CHK_MODEL, CHK_BEAT} chk_kind_type;
   typedef enum logic       {ROW_ITEM, ROW_CFG} row_kind_type;
   typedef enum int         {GEN_MIXED, GEN_CLEAN, GEN_RUNAWAY} gen_mode_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      item_type              it;
      chk_kind_type          chk;
      result_type            want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pk1unpad_req_if req_if ();
   pk1unpad_rsp_if rsp_if ();
   pk1unpad_csr_if csr_if ();

   pkcs1_v15_encryption_unpad #(
      .MAX_BLOCK_BYTES(MAX_BLOCK)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // decoder copy of registers and block state
   int              cfg_mod = MODULUS_BYTES_RESET;
   int              cfg_cap = OUTPUT_CAPACITY_RESET;
   unpad_phase_type blk_phase = ST_LEAD;
   int              blk_idx = 0;
   int              blk_len = 0;
   bit              fmt_err = 1'b0;
   bit              cap_err = 1'b0;

   result_type  pending_beats[$];
   item_type    blk_items[$];
   int          mismatch_cnt = 0;
   int unsigned cycle_cnt = 0;
   bit          req_gaps_on = 1'b1;
   bit          rsp_stalls_on = 1'b1;
   int          long_hold = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("pkcs1_v15_encryption_unpad_tb: done, errors");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      mismatch_cnt++;
   endtask

   // Decode one byte; return whether it gives a response beat and its contents.
   function automatic void decode_byte(input item_type it, output bit has,
                                       output result_type res);
      int idx;
      int used;
      int mlen;
      bit was_msg;
      bit emit;
      idx = blk_idx;
      was_msg = (blk_phase == ST_MSG);
      if (blk_phase == ST_LEAD) begin
         blk_len = it.total_len;
         if (blk_len > MAX_BLOCK) fmt_err = 1'b1;
         if (blk_len == cfg_mod) begin
            if (it.in_byte != 8'h00) fmt_err = 1'b1;
            blk_phase = ST_MARK;
         end else begin
            if (blk_len + 1 != cfg_mod) fmt_err = 1'b1;
            if (it.in_byte != MARKER_BYTE) fmt_err = 1'b1;
            blk_phase = ST_PAD;
         end
      end else begin
         if (int'(it.total_len) != blk_len) fmt_err = 1'b1;
         if (blk_phase == ST_MARK) begin
            if (it.in_byte != MARKER_BYTE) fmt_err = 1'b1;
            blk_phase = ST_PAD;
         end else if (blk_phase == ST_PAD && it.in_byte == 8'h00) begin
            // separator: the rest of the block is the message
            used = idx + 1;
            mlen = (blk_len > used) ? blk_len - used : 0;
            if (mlen > cfg_cap) cap_err = 1'b1;
            blk_phase = ST_MSG;
         end
      end
      if (idx >= blk_len) fmt_err = 1'b1;
      if (it.is_last) begin
         if (idx + 1 != blk_len) fmt_err = 1'b1;
         if (blk_phase != ST_MSG) fmt_err = 1'b1;
      end
      emit = was_msg && !fmt_err && !cap_err;
      if (blk_idx < IDX_SAT) blk_idx++;

      has = emit || it.is_last;
      res = '0;
      if (emit) begin
         res.out_byte = it.in_byte;
         res.byte_valid = 1'b1;
      end
      res.done_res = it.is_last;
      res.status = STATUS_OK;
      if (it.is_last) begin
         if (fmt_err) res.status = STATUS_FORMAT;
         else if (cap_err) res.status = STATUS_CAPACITY;
         blk_phase = ST_LEAD;
         blk_idx = 0;
         blk_len = 0;
         fmt_err = 1'b0;
         cap_err = 1'b0;
      end
   endfunction

   function automatic dir_row_type r_cfg(input logic [CSR_IDX_W-1:0] idx, input int val);
      dir_row_type r;
      r = '0;
      r.kind = ROW_CFG;
      r.reg_idx = idx;
      r.reg_val = CSR_DATA_W'(val);
      return r;
   endfunction

   function automatic dir_row_type r_item(input int b, input int len, input bit last,
                                          input chk_kind_type chk);
      dir_row_type r;
      r = '0;
      r.kind = ROW_ITEM;
      r.it.in_byte = BYTE_W'(b);
      r.it.total_len = LEN_W'(len);
      r.it.is_last = last;
      r.chk = chk;
      return r;
   endfunction

   // last byte of a block with its done beat typed in
   function automatic dir_row_type r_done(input int b, input int len, input int ob,
                                          input bit bv, input logic [STATUS_W-1:0] st);
      dir_row_type r;
      r = r_item(b, len, 1'b1, CHK_BEAT);
      r.want.out_byte = BYTE_W'(ob);
      r.want.byte_valid = bv;
      r.want.done_res = 1'b1;
      r.want.status = st;
      return r;
   endfunction

   function automatic void push_byte(input int b, input int len);
      item_type it;
      it.in_byte = BYTE_W'(b);
      it.total_len = LEN_W'(len);
      it.is_last = 1'b0;
      blk_items.push_back(it);
   endfunction

   // Build one block into blk_items; damaged blocks start from a clean one.
   function automatic void make_block(input int k, input gen_mode_type mode);
      int  len;
      int  rest;
      int  pad;
      int  mark_pos;
      int  bad;
      int  n;
      bit  lead;
      blk_items.delete();
      if (mode == GEN_RUNAWAY) begin
         // run the byte index into saturation before ending the block
         len = $urandom_range(0, 1023);
         repeat (1030) push_byte($urandom_range(0, 255), len);
      end else begin
         lead = (k < 2) ? 1'b1 : 1'($urandom_range(0, 1));
         len = lead ? k : k - 1;
         mark_pos = lead ? 1 : 0;
         if (lead) push_byte(0, len);
         push_byte(MARKER_BYTE, len);
         rest = len - blk_items.size();
         if (rest > 0) begin
            pad = $urandom_range(0, rest - 1);
            repeat (pad) push_byte($urandom_range(1, 255), len);
            push_byte(0, len);
            repeat (rest - 1 - pad) push_byte($urandom_range(0, 255), len);
         end
         if (mode == GEN_MIXED && $urandom_range(0, 99) >= 70) begin
            case ($urandom_range(0, 7))
               0: begin
                  bad = $urandom_range(0, 1023);
                  foreach (blk_items[i]) blk_items[i].total_len = LEN_W'(bad);
               end
               1: begin
                  n = $urandom_range(0, blk_items.size() - 1);
                  blk_items[n].total_len ^= LEN_W'($urandom_range(1, 1023));
               end
               2: repeat ($urandom_range(1, 3)) push_byte($urandom_range(0, 255), len);
               3: begin
                  if (blk_items.size() > 1)
                     repeat ($urandom_range(1, blk_items.size() - 1)) void'(blk_items.pop_back());
               end
               4: begin
                  if (blk_items.size() > mark_pos)
                     blk_items[mark_pos].in_byte = MARKER_BYTE ^ BYTE_W'($urandom_range(1, 255));
               end
               5: begin
                  // drop the separator and any zero after it
                  foreach (blk_items[i])
                     if (i > mark_pos && blk_items[i].in_byte == 8'h00)
                        blk_items[i].in_byte = BYTE_W'($urandom_range(1, 255));
               end
               6: begin
                  if (lead) blk_items[0].in_byte = BYTE_W'($urandom_range(1, 255));
                  else push_byte(0, len);
               end
               default: begin
                  blk_items.delete();
                  bad = $urandom_range(0, 1023);
                  repeat ($urandom_range(1, 8)) push_byte($urandom_range(0, 255), bad);
               end
            endcase
         end
      end
      blk_items[blk_items.size() - 1].is_last = 1'b1;
   endfunction

   task automatic wait_drained();
      while (pending_beats.size() != 0) @(posedge clock);
      // bytes that give no beat may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= CSR_DATA_W'(val);
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == CSR_MODULUS_BYTES) cfg_mod = val;
      else if (idx == CSR_OUTPUT_CAPACITY) cfg_cap = val;
   endtask

   task automatic send_byte(input item_type it, input chk_kind_type chk,
                            input result_type want);
      bit         has;
      result_type pred;
      int         gap;
      req_if.valid <= 1'b1;
      req_if.in_byte <= it.in_byte;
      req_if.total_len <= it.total_len;
      req_if.is_last <= it.is_last;
      do @(posedge clock); while (!req_if.ready);
      decode_byte(it, has, pred);
      case (chk)
         CHK_MODEL: if (has) pending_beats.push_back(pred);
         CHK_BEAT:  pending_beats.push_back(want);
         default:   ;
      endcase
      gap = req_gaps_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response side
   initial begin
      int         stall;
      result_type got;
      result_type want;
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold > 0) begin
            stall = long_hold;
            long_hold = 0;
         end else begin
            stall = rsp_stalls_on ? $urandom_range(0, 19) : 0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got.out_byte = rsp_if.out_byte;
         got.byte_valid = rsp_if.byte_valid;
         got.done_res = rsp_if.done_res;
         got.status = rsp_if.status;
         if (pending_beats.size() == 0) begin
            flag_mismatch("beat with nothing pending", int'(got), 0);
         end else begin
            want = pending_beats.pop_front();
            if (got.out_byte !== want.out_byte)
               flag_mismatch("out_byte", got.out_byte, want.out_byte);
            if (got.byte_valid !== want.byte_valid)
               flag_mismatch("byte_valid", got.byte_valid, want.byte_valid);
            if (got.done_res !== want.done_res)
               flag_mismatch("done_res", got.done_res, want.done_res);
            if (got.status !== want.status)
               flag_mismatch("status", got.status, want.status);
         end
      end
   end

   // request side and register writes
   initial begin
      dir_row_type  dir_tab[$];
      gen_mode_type mode;
      int           k;
      int           cap;
      int           phase_no;
      int           phase_items;
      int           blk_no;
      int           random_sent;

      req_if.valid <= 1'b0;
      req_if.in_byte <= '0;
      req_if.total_len <= '0;
      req_if.is_last <= 1'b0;
      csr_if.valid <= 1'b0;
      csr_if.index <= '0;
      csr_if.data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      dir_tab = '{
         // reset settings: wrong length, then field extremes and oversized length
         r_done(8'h00, 0, 8'h00, 1'b0, STATUS_FORMAT),
         r_done(8'hFF, 1023, 8'h00, 1'b0, STATUS_FORMAT),
         r_cfg(CSR_MODULUS_BYTES, 4),
         // full block with leading zero, one message byte
         r_item(8'h00, 4, 1'b0, CHK_MODEL),
         r_item(8'h02, 4, 1'b0, CHK_MODEL),
         r_item(8'h00, 4, 1'b0, CHK_MODEL),
         r_item(8'hAB, 4, 1'b1, CHK_MODEL),
         // no leading zero, separator last: empty message
         r_item(8'h02, 3, 1'b0, CHK_MODEL),
         r_item(8'h55, 3, 1'b0, CHK_MODEL),
         r_item(8'h00, 3, 1'b1, CHK_MODEL),
         // block ends inside the padding
         r_item(8'h02, 3, 1'b0, CHK_MODEL),
         r_item(8'h77, 3, 1'b0, CHK_MODEL),
         r_done(8'h88, 3, 8'h00, 1'b0, STATUS_FORMAT),
         // one byte beyond the block length
         r_item(8'h02, 3, 1'b0, CHK_MODEL),
         r_item(8'h00, 3, 1'b0, CHK_MODEL),
         r_item(8'h44, 3, 1'b0, CHK_MODEL),
         r_done(8'h55, 3, 8'h00, 1'b0, STATUS_FORMAT),
         r_cfg(CSR_OUTPUT_CAPACITY, 0),
         // message longer than the capacity
         r_item(8'h02, 3, 1'b0, CHK_MODEL),
         r_item(8'h00, 3, 1'b0, CHK_MODEL),
         r_done(8'hAA, 3, 8'h00, 1'b0, STATUS_CAPACITY),
         // short block, changing length and capacity overrun together
         r_item(8'h00, 4, 1'b0, CHK_MODEL),
         r_item(8'h02, 5, 1'b0, CHK_MODEL),
         r_done(8'h00, 4, 8'h00, 1'b0, STATUS_FORMAT),
         r_cfg(CSR_MODULUS_BYTES, 0),
         r_done(8'h00, 0, 8'h00, 1'b0, STATUS_FORMAT)
      };

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CFG) begin
            req_if.valid <= 1'b0;
            write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
         end else begin
            send_byte(dir_tab[i].it, dir_tab[i].chk, dir_tab[i].want);
         end
      end

      phase_no = 0;
      random_sent = 0;
      while (random_sent < ITEM_TARGET) begin
         case (phase_no)
            0: begin
               k = 512;
               cap = 512;
            end
            1: begin
               k = 1;
               cap = 0;
            end
            2: begin
               k = 40;
               cap = 512;
            end
            default: begin
               k = $urandom_range(2, 48);
               cap = $urandom_range(0, 1) ? 512 : $urandom_range(0, k);
            end
         endcase
         req_if.valid <= 1'b0;
         write_reg(CSR_MODULUS_BYTES, k);
         write_reg(CSR_OUTPUT_CAPACITY, cap);
         req_gaps_on = (phase_no % 4 != 3);
         rsp_stalls_on = (phase_no % 4 != 3) && (phase_no % 5 != 4);
         // starve the response side while bytes keep coming
         if (phase_no == 2) long_hold = 300;

         phase_items = 0;
         blk_no = 0;
         do begin
            if (phase_no == 0 || phase_no == 2) mode = GEN_CLEAN;
            else if (phase_no == 4 && blk_no == 0) mode = GEN_RUNAWAY;
            else mode = GEN_MIXED;
            make_block(k, mode);
            foreach (blk_items[i]) send_byte(blk_items[i], CHK_MODEL, result_type'(0));
            phase_items += blk_items.size();
            random_sent += blk_items.size();
            // hold the sender until every pending beat is back
            if (blk_no == 3) begin
               req_if.valid <= 1'b0;
               wait_drained();
            end
            blk_no++;
         end while (phase_no != 0 && phase_items < PHASE_ITEMS);
         phase_no++;
      end

      req_if.valid <= 1'b0;
      wait_drained();
      if (mismatch_cnt == 0) begin
         $display("pkcs1_v15_encryption_unpad_tb: done, clean");
      end else begin
         $display("pkcs1_v15_encryption_unpad_tb: done, errors");
      end
      $finish;
   end

endmodule
